// ===== hw/rtl/pasp_pkg.sv =====
// Package with shared constants, types and a helper function for the arity stack planner.
`default_nettype none

package pasp_pkg;

    localparam int MAX_FRAMES  = 256;
    localparam int COUNT_WIDTH = 16;
    localparam int ADDR_W      = $clog2(MAX_FRAMES);
    localparam int DEPTH_W     = $clog2(MAX_FRAMES + 1);
    localparam int IN_COUNT_W  = 16;
    localparam int POS_W       = 16;
    localparam int PEAK_W      = 9;
    localparam int LIMIT_W     = 9;
    localparam int PEAK_MAX    = 511;
    localparam int LIMIT_RESET = 256;

    typedef enum logic [1:0] {
        STATUS_ACCEPTED    = 2'd0,
        STATUS_LIMIT       = 2'd1,
        STATUS_NO_CONVERGE = 2'd2,
        STATUS_DONE        = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [POS_W-1:0]    node_position;
        logic [PEAK_W-1:0]   peak_frames;
        logic [PEAK_W-1:0]   peak_operands;
    } result_t;

    function automatic logic [PEAK_W-1:0] peak_out(input logic [DEPTH_W-1:0] value);
        logic [31:0] wide;
        wide = 32'(value);
        if (wide > 32'(PEAK_MAX)) begin
            return PEAK_W'(PEAK_MAX);
        end
        return PEAK_W'(wide);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/preorder_arity_stack_planner.sv =====
// Top level of the preorder arity stack planner: ports, limit register and output register.
//
// Channel  Direction  Handshake            Transaction contents
// in       input      in_valid / in_stall  num_children, is_end
// out      output     out_valid / out_stall status, node_position, peak_frames, peak_operands
// cfg      input      cfg_valid / cfg_ready max_open
//
// A node passes from idle through pop to emit; each finished frame that it pops from a deeper
// stack adds a wait and a further pop, and the pop that leaves the stack empty adds one pop.
// The pop loop waits in the wait state for the registered read of the counter memory.
// Reset clears all control state; the counter memory needs no clearing pass.
// A result waits in the output register while the next transaction is accepted.
`default_nettype none

module preorder_arity_stack_planner (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [pasp_pkg::IN_COUNT_W-1:0]    num_children,
    input  wire logic                               is_end,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              status,
    output logic [pasp_pkg::POS_W-1:0]              node_position,
    output logic [pasp_pkg::PEAK_W-1:0]             peak_frames,
    output logic [pasp_pkg::PEAK_W-1:0]             peak_operands,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pasp_pkg::LIMIT_W-1:0]       max_open
);

    logic [pasp_pkg::LIMIT_W-1:0] limit_reg;
    logic                         out_valid_reg;
    pasp_pkg::result_t            out_reg;
    logic                         engine_idle;
    logic                         res_valid;
    logic                         res_ready;
    pasp_pkg::result_t            res;

    assign cfg_ready = 1'b1;
    assign in_stall  = !engine_idle;
    assign res_ready = !out_valid_reg || !out_stall;

    pasp_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_valid && engine_idle),
        .num_children (num_children),
        .is_end       (is_end),
        .max_open     (limit_reg),
        .res_ready    (res_ready),
        .idle         (engine_idle),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= pasp_pkg::LIMIT_W'(pasp_pkg::LIMIT_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= max_open;
            end
            if (res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign node_position = out_reg.node_position;
    assign peak_frames   = out_reg.peak_frames;
    assign peak_operands = out_reg.peak_operands;

`ifndef NO_ASSERTIONS
    // Frame depth and operand depth move together, so their peaks agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> peak_frames == peak_operands)
        else $error("peak frame and operand depths differ");

    // An accepted node has pushed a frame, so the peak is at least one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == pasp_pkg::STATUS_ACCEPTED) |-> peak_frames != '0)
        else $error("accepted node reports zero peak depth");

    // One transaction is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transaction is in work");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pasp_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module pasp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pasp_engine.sv =====
// Stack engine: sequencer, top-of-stack register and the counter memory below it.
`default_nettype none

module pasp_engine (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [pasp_pkg::IN_COUNT_W-1:0]     num_children,
    input  wire logic                                is_end,
    input  wire logic [pasp_pkg::LIMIT_W-1:0]        max_open,
    input  wire logic                                res_ready,
    output logic                                     idle,
    output logic                                     res_valid,
    output pasp_pkg::result_t                        res
);

    pasp_pkg::state_t                      state_reg, state_next;
    logic [pasp_pkg::DEPTH_W-1:0]          depth_reg, depth_next;
    logic [pasp_pkg::DEPTH_W-1:0]          peak_reg, peak_next;
    logic [pasp_pkg::POS_W-1:0]            pos_reg, pos_next;
    pasp_pkg::status_t                     err_reg, err_next;
    logic [pasp_pkg::COUNT_WIDTH-1:0]      top_reg, top_next;
    logic [pasp_pkg::COUNT_WIDTH-1:0]      count_reg, count_next;
    logic                                  end_reg, end_next;

    logic                                  wr_en;
    logic [pasp_pkg::ADDR_W-1:0]           wr_addr;
    logic [pasp_pkg::COUNT_WIDTH-1:0]      wr_data;
    logic                                  rd_en;
    logic [pasp_pkg::ADDR_W-1:0]           rd_addr;
    logic [pasp_pkg::COUNT_WIDTH-1:0]      rd_data;

    logic [pasp_pkg::DEPTH_W-1:0]          depth_inc;
    logic [pasp_pkg::DEPTH_W-1:0]          peak_push;
    logic                                  stack_full;

    pasp_ram #(
        .WIDTH (pasp_pkg::COUNT_WIDTH),
        .DEPTH (pasp_pkg::MAX_FRAMES)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign depth_inc  = depth_reg + pasp_pkg::DEPTH_W'(1);
    assign peak_push  = (depth_inc > peak_reg) ? depth_inc : peak_reg;
    assign stack_full = (32'(depth_reg) >= 32'(max_open)) ||
                        (32'(depth_reg) >= 32'(pasp_pkg::MAX_FRAMES));
    assign idle       = (state_reg == pasp_pkg::S_IDLE);
    assign wr_addr    = pasp_pkg::ADDR_W'(depth_reg - pasp_pkg::DEPTH_W'(1));
    assign wr_data    = top_reg - pasp_pkg::COUNT_WIDTH'(1);
    assign rd_addr    = pasp_pkg::ADDR_W'(depth_reg - pasp_pkg::DEPTH_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pasp_pkg::S_IDLE;
            depth_reg <= '0;
            peak_reg  <= '0;
            pos_reg   <= '0;
            err_reg   <= pasp_pkg::STATUS_ACCEPTED;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            peak_reg  <= peak_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        count_reg <= count_next;
        end_reg   <= end_next;
    end

    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        peak_next  = peak_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        count_next = count_reg;
        end_next   = end_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        res_valid  = 1'b0;
        res.status        = err_reg;
        res.node_position = pos_reg;
        res.peak_frames   = pasp_pkg::peak_out(peak_reg);
        res.peak_operands = pasp_pkg::peak_out(peak_reg);

        unique case (state_reg)
            pasp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    count_next = pasp_pkg::COUNT_WIDTH'(num_children);
                    end_next   = is_end;
                    state_next = pasp_pkg::S_POP;
                end
            end
            pasp_pkg::S_POP:
            begin
                if (err_reg == pasp_pkg::STATUS_ACCEPTED && depth_reg != '0 &&
                    top_reg == '0)
                begin
                    depth_next = depth_reg - pasp_pkg::DEPTH_W'(1);
                    if (depth_reg > pasp_pkg::DEPTH_W'(1))
                    begin
                        rd_en      = 1'b1;
                        state_next = pasp_pkg::S_WAIT;
                    end
                end
                else
                begin
                    state_next = pasp_pkg::S_EMIT;
                end
            end
            pasp_pkg::S_WAIT:
            begin
                top_next   = rd_data;
                state_next = pasp_pkg::S_POP;
            end
            pasp_pkg::S_EMIT:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = pasp_pkg::S_IDLE;
                    if (end_reg)
                    begin
                        if (err_reg != pasp_pkg::STATUS_ACCEPTED)
                        begin
                            res.status = err_reg;
                        end
                        else if (depth_reg != '0)
                        begin
                            res.status = pasp_pkg::STATUS_NO_CONVERGE;
                        end
                        else
                        begin
                            res.status = pasp_pkg::STATUS_DONE;
                        end
                        depth_next = '0;
                        peak_next  = '0;
                        pos_next   = '0;
                        err_next   = pasp_pkg::STATUS_ACCEPTED;
                    end
                    else if (err_reg != pasp_pkg::STATUS_ACCEPTED)
                    begin
                        res.status = err_reg;
                    end
                    else if (stack_full)
                    begin
                        res.status = pasp_pkg::STATUS_LIMIT;
                        err_next   = pasp_pkg::STATUS_LIMIT;
                    end
                    else
                    begin
                        // The parent's counter, less one, moves into memory; the new frame becomes the top.
                        wr_en             = (depth_reg != '0);
                        top_next          = count_reg;
                        depth_next        = depth_inc;
                        peak_next         = peak_push;
                        pos_next          = pos_reg + pasp_pkg::POS_W'(1);
                        res.status        = pasp_pkg::STATUS_ACCEPTED;
                        res.peak_frames   = pasp_pkg::peak_out(peak_push);
                        res.peak_operands = pasp_pkg::peak_out(peak_push);
                    end
                end
            end
            default:
            begin
                state_next = pasp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
